// ----- rtl/core/ultrasonic_ranging_beeper_defines.svh -----
// Assertion macros shared by the ranging beeper RTL.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef ULTRASONIC_RANGING_BEEPER_DEFINES_SVH
`define ULTRASONIC_RANGING_BEEPER_DEFINES_SVH

// Property checked on every rising clock edge while out of reset.
`define URB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication checked on every rising clock edge, reset included.
`define URB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/core/urb_pkg.sv -----
// Types, constants and the distance band table of the ultrasonic ranging beeper.
// No dependencies.
`default_nettype none

package urb_pkg;

  localparam int unsigned DIST_BITS = 10;
  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
  localparam logic [DIST_BITS-1:0] DIST_RESET = DIST_BITS'(999);

  // Ticks / 58 is computed as (ticks >> 1) * ceil(2^20 / 29) >> 20, exact for 15-bit inputs.
  localparam int unsigned    CM_SHIFT = 20;
  localparam logic [15:0]    CM_RECIP = 16'd36158;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_TRIGGER_WIDTH = 3'd0,
    REG_ECHO_TIMEOUT  = 3'd1,
    REG_PAUSE         = 3'd2,
    REG_TICKS_PER_MS  = 3'd3,
    REG_TONE_PERIOD   = 3'd4,
    REG_TONE_HIGH     = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_TRIGGER = 2'd0,
    PH_WAIT    = 2'd1,
    PH_MEASURE = 2'd2,
    PH_PAUSE   = 2'd3
  } range_phase_e;

  typedef struct packed {
    logic [9:0] on_ms;
    logic [9:0] off_ms;
  } band_t;

  // On and off beep times for a distance in centimeters.
  function automatic band_t pick_band(input logic [DIST_BITS-1:0] dist_cm);
    band_t b;
    priority if (dist_cm <= DIST_BITS'(5)) begin
      b = '{on_ms: 10'd50, off_ms: 10'd0};
    end else if (dist_cm <= DIST_BITS'(10)) begin
      b = '{on_ms: 10'd70, off_ms: 10'd70};
    end else if (dist_cm <= DIST_BITS'(20)) begin
      b = '{on_ms: 10'd90, off_ms: 10'd150};
    end else if (dist_cm <= DIST_BITS'(30)) begin
      b = '{on_ms: 10'd100, off_ms: 10'd250};
    end else if (dist_cm <= DIST_BITS'(50)) begin
      b = '{on_ms: 10'd100, off_ms: 10'd400};
    end else if (dist_cm <= DIST_BITS'(70)) begin
      b = '{on_ms: 10'd50, off_ms: 10'd700};
    end else if (dist_cm <= DIST_BITS'(100)) begin
      b = '{on_ms: 10'd50, off_ms: 10'd1000};
    end else begin
      b = '{on_ms: 10'd0, off_ms: 10'd100};
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ultrasonic_ranging_beeper.sv -----
// Ultrasonic ranging sequencer and parking beeper, one request per microsecond tick.
// An accepted request's result is in the output register in the cycle after its acceptance.
// Throughput: one request per cycle; the output register takes a new result while the
// previous one is read in the same cycle, so the rate is set by the downstream ready only.
// Reset (rst_ni low, asynchronous): registers to defaults, trigger phase, distance 999.
// Depends on urb_pkg and ultrasonic_ranging_beeper_defines.svh.
`default_nettype none

`include "ultrasonic_ranging_beeper_defines.svh"

module ultrasonic_ranging_beeper (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Slave side: tdata[0] = echo_level, tdata[7:1] zero.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  // Master side: tdata[0] = trigger_level, [1] = tone_level, [11:2] = distance_cm,
  // [12] = distance_update, [15:13] zero.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [17:0] cfg_data_i
);

  localparam int unsigned DB = urb_pkg::DIST_BITS;

  // Configuration registers.
  logic [9:0]  trig_width_q, ticks_per_ms_q, tone_period_q, tone_high_q;
  logic [15:0] echo_timeout_q;
  logic [17:0] pause_q;

  // Sequencer and beeper state.
  urb_pkg::range_phase_e phase_q, phase_d;
  logic [17:0] phase_ticks_q, phase_ticks_d;
  logic [15:0] pulse_ticks_q, pulse_ticks_d;
  logic [DB-1:0] dist_q, dist_d;
  logic        beep_on_q, beep_on_d;
  logic [9:0]  ms_count_q, ms_count_d;
  logic [9:0]  sub_ms_q, sub_ms_d;
  logic [9:0]  band_on_q, band_off_q, band_on_d, band_off_d;
  logic [9:0]  carrier_q, carrier_d;

  // Output register.
  logic        out_valid_q;
  logic        out_trig_q, out_tone_q, out_upd_q;
  logic [DB-1:0] out_dist_q;

  logic        accept;
  logic        echo;
  logic        trig, gate, carrier_hi, update_d;
  logic        pattern_start;
  urb_pkg::band_t band_tbl;
  logic [10:0] sub_inc, carrier_inc;
  logic [9:0]  tpm_eff;
  logic        beep_on_mid;
  logic [9:0]  ms_mid;
  logic [18:0] phase_inc;
  logic [17:0] trig_limit, pause_limit;
  logic [15:0] timeout_limit;
  logic [30:0] cm_prod;
  logic [10:0] cm_quot;
  logic [DB-1:0] cm_sat;

  assign echo          = s_axis_tdata[0];
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Pulse length to centimeters, saturated.
  assign cm_prod = 31'(pulse_ticks_q[15:1]) * 31'(urb_pkg::CM_RECIP);
  assign cm_quot = cm_prod[30:urb_pkg::CM_SHIFT];
  assign cm_sat  = (cm_quot > 11'(urb_pkg::DIST_MAX)) ? urb_pkg::DIST_MAX : cm_quot[DB-1:0];

  assign band_tbl      = urb_pkg::pick_band(dist_q);
  assign tpm_eff       = (ticks_per_ms_q == 10'd0) ? 10'd1 : ticks_per_ms_q;
  assign trig_limit    = (trig_width_q == 10'd0) ? 18'd1 : 18'(trig_width_q);
  assign timeout_limit = (echo_timeout_q == 16'd0) ? 16'd1 : echo_timeout_q;
  assign pause_limit   = (pause_q == 18'd0) ? 18'd1 : pause_q;

  // Beeper and carrier.
  always_comb begin
    pattern_start = beep_on_q && (ms_count_q == 10'd0) && (sub_ms_q == 10'd0);
    band_on_d     = pattern_start ? band_tbl.on_ms  : band_on_q;
    band_off_d    = pattern_start ? band_tbl.off_ms : band_off_q;
    gate          = beep_on_q && (ms_count_q < band_on_d);

    sub_inc = 11'(sub_ms_q) + 11'd1;
    if (sub_inc >= 11'(tpm_eff)) begin
      sub_ms_d = 10'd0;
      ms_mid   = ms_count_q + 10'd1;
    end else begin
      sub_ms_d = sub_inc[9:0];
      ms_mid   = ms_count_q;
    end
    ms_count_d  = ms_mid;
    beep_on_mid = beep_on_q;
    if (beep_on_q && (ms_mid >= band_on_d)) begin
      beep_on_mid = 1'b0;
      ms_count_d  = 10'd0;
      sub_ms_d    = 10'd0;
    end
    beep_on_d = beep_on_mid;
    // The off phase may end in the same tick the on phase ended.
    if (!beep_on_mid && (ms_count_d >= band_off_d)) begin
      beep_on_d  = 1'b1;
      ms_count_d = 10'd0;
      sub_ms_d   = 10'd0;
    end

    carrier_hi  = carrier_q < tone_high_q;
    carrier_inc = 11'(carrier_q) + 11'd1;
    carrier_d   = (carrier_inc >= 11'(tone_period_q)) ? 10'd0 : carrier_inc[9:0];
  end

  // Ranging sequencer: next phase and outputs.
  always_comb begin
    phase_d       = phase_q;
    phase_ticks_d = phase_ticks_q;
    pulse_ticks_d = pulse_ticks_q;
    dist_d        = dist_q;
    update_d      = 1'b0;
    trig          = 1'b0;
    phase_inc     = 19'(phase_ticks_q) + 19'd1;
    unique case (phase_q)
      urb_pkg::PH_TRIGGER: begin
        trig = 1'b1;
        if (phase_inc >= 19'(trig_limit)) begin
          phase_d       = urb_pkg::PH_WAIT;
          phase_ticks_d = 18'd0;
        end else begin
          phase_ticks_d = phase_inc[17:0];
        end
      end
      urb_pkg::PH_WAIT: begin
        if (echo) begin
          phase_d       = urb_pkg::PH_MEASURE;
          pulse_ticks_d = 16'd1;
          phase_ticks_d = 18'd0;
        end else if (phase_inc >= 19'(timeout_limit)) begin
          // A missed echo rise reports distance zero.
          dist_d        = '0;
          update_d      = 1'b1;
          phase_d       = urb_pkg::PH_PAUSE;
          phase_ticks_d = 18'd0;
        end else begin
          phase_ticks_d = phase_inc[17:0];
        end
      end
      urb_pkg::PH_MEASURE: begin
        if (!echo || (pulse_ticks_q >= echo_timeout_q)) begin
          dist_d        = cm_sat;
          update_d      = 1'b1;
          phase_d       = urb_pkg::PH_PAUSE;
          phase_ticks_d = 18'd0;
        end else begin
          pulse_ticks_d = pulse_ticks_q + 16'd1;
        end
      end
      urb_pkg::PH_PAUSE: begin
        if (phase_inc >= 19'(pause_limit)) begin
          phase_d       = urb_pkg::PH_TRIGGER;
          phase_ticks_d = 18'd0;
        end else begin
          phase_ticks_d = phase_inc[17:0];
        end
      end
      default: begin
        phase_d = urb_pkg::PH_TRIGGER;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= urb_pkg::PH_TRIGGER;
    end else if (accept) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_width_q   <= 10'd10;
      echo_timeout_q <= 16'd50000;
      pause_q        <= 18'd60000;
      ticks_per_ms_q <= 10'd1000;
      tone_period_q  <= 10'd1000;
      tone_high_q    <= 10'd500;
    end else if (cfg_we_i) begin
      unique case (urb_pkg::reg_idx_e'(cfg_idx_i))
        urb_pkg::REG_TRIGGER_WIDTH: trig_width_q   <= cfg_data_i[9:0];
        urb_pkg::REG_ECHO_TIMEOUT:  echo_timeout_q <= cfg_data_i[15:0];
        urb_pkg::REG_PAUSE:         pause_q        <= cfg_data_i;
        urb_pkg::REG_TICKS_PER_MS:  ticks_per_ms_q <= cfg_data_i[9:0];
        urb_pkg::REG_TONE_PERIOD:   tone_period_q  <= cfg_data_i[9:0];
        urb_pkg::REG_TONE_HIGH:     tone_high_q    <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= 18'd0;
      pulse_ticks_q <= 16'd0;
      dist_q        <= urb_pkg::DIST_RESET;
      beep_on_q     <= 1'b1;
      ms_count_q    <= 10'd0;
      sub_ms_q      <= 10'd0;
      band_on_q     <= 10'd0;
      band_off_q    <= 10'd0;
      carrier_q     <= 10'd0;
    end else if (accept) begin
      phase_ticks_q <= phase_ticks_d;
      pulse_ticks_q <= pulse_ticks_d;
      dist_q        <= dist_d;
      beep_on_q     <= beep_on_d;
      ms_count_q    <= ms_count_d;
      sub_ms_q      <= sub_ms_d;
      band_on_q     <= band_on_d;
      band_off_q    <= band_off_d;
      carrier_q     <= carrier_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_trig_q <= trig;
      out_tone_q <= gate && carrier_hi;
      out_dist_q <= dist_d;
      out_upd_q  <= update_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_upd_q, out_dist_q, out_tone_q, out_trig_q};

  `URB_ASSERT(a_result_follows, accept |=> out_valid_q, "accepted request left no result")
  `URB_ASSERT_ALWAYS(a_stall_only_when_full, !s_axis_tready |-> (out_valid_q && !m_axis_tready),
    "input stalled without a pending result")
  `URB_ASSERT(a_update_enters_pause, (accept && update_d) |=> (phase_q == urb_pkg::PH_PAUSE),
    "distance stored without moving to pause")
  `URB_ASSERT(a_trigger_no_update, (out_valid_q && out_trig_q) |-> !out_upd_q,
    "distance update during trigger pulse")

endmodule

`default_nettype wire
